/* rtl/kcs_pkg.sv */
// Package for the keyframe curve segment evaluator.
// Holds the table geometry, the entry record, the divider cell record and the FSM states.
// No dependencies.
package kcs_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = 7;
    localparam int TIME_W       = 32;
    localparam int VAL_W        = 32;
    localparam int DIV_STEPS    = 32;

    typedef logic [SEG_AW-1:0] t_seg_addr;

    // Segment kinds.
    typedef enum logic [1:0] {
        KIND_LINEAR  = 2'd0,
        KIND_BEZIER  = 2'd1,
        KIND_STEP    = 2'd2,
        KIND_INVSTEP = 2'd3
    } t_kind;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One table entry.
    typedef struct packed {
        logic [1:0]              kind;
        logic [TIME_W-1:0]       start_time;
        logic signed [VAL_W-1:0] start_value;
        logic signed [VAL_W-1:0] ctrl1_value;
        logic signed [VAL_W-1:0] ctrl2_value;
        logic [TIME_W-1:0]       end_time;
        logic signed [VAL_W-1:0] end_value;
    } t_entry;

    // Data handed from one divider cell to the next.
    typedef struct packed {
        logic              vld;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] quo;
        logic [TIME_W-1:0] span;
    } t_div;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

endpackage

/* rtl/kcs_div_cell.sv */
// One restoring-division cell: brings in one dividend bit and forms one quotient bit.
// Depends on kcs_pkg.
module kcs_div_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  kcs_pkg::t_div i_div,
    input  logic         i_bit,
    output kcs_pkg::t_div o_div
);
    import kcs_pkg::*;

    logic [TIME_W:0]   shifted;
    logic              ge;
    logic [TIME_W:0]   diff;
    t_div              r_div;

    // Shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted = {i_div.rem, i_bit};
        diff    = shifted - {1'b0, i_div.span};
        ge      = (shifted >= {1'b0, i_div.span});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div.vld <= 1'b0;
        end else begin
            r_div.vld <= i_div.vld;
        end
        r_div.rem  <= ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
        r_div.quo  <= {i_div.quo[TIME_W-2:0], ge};
        r_div.span <= i_div.span;
    end

    assign o_div = r_div;

endmodule

/* rtl/kcs_table.sv */
// Segment table memory: one write port and one read port with registered read data.
// Depends on kcs_pkg.
module kcs_table (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  kcs_pkg::t_seg_addr i_wr_addr,
    input  kcs_pkg::t_entry    i_wr_data,
    input  logic               i_rd_en,
    input  kcs_pkg::t_seg_addr i_rd_addr,
    output kcs_pkg::t_entry    o_rd_data
);
    import kcs_pkg::*;

    t_entry r_mem [MAX_SEGMENTS];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/keyframe_curve_segment_evaluator.sv */
// Top level of the keyframe curve segment evaluator.
// Depends on kcs_pkg, kcs_table and kcs_div_cell.
//
// Usage:
// An item is transferred when i_start is high and o_busy is low. A write item
// (i_cmd low) loads one table entry; a query item (i_cmd high) evaluates the
// curve at i_query_time. Each item gives exactly one result, shown on
// o_curve_value and o_found for one cycle while o_done is high; the receiver
// cannot hold it off. The segment count register is written through the
// i_cfg_valid / o_cfg_ready channel (ready is always high); the user must
// write it only while idle, as the block does not enforce this. A write item
// shows its result in the cycle after the transfer. A query scans one entry
// per cycle through the table read port until a match or the end of the
// count, then the ratio passes a chain of 32 divider cells, then each lerp
// passes the one multiplier in a multiply state and an add state: one lerp
// for linear, six for Bezier, none for the stepped kinds. The result is then
// shown in the done state; the next item can be taken in the cycle after it.
// One item is in work at a time. Reset clears the control state and the
// segment count; table entries are undefined until written.
module keyframe_curve_segment_evaluator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kcs_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_cmd,
    input  logic [5:0]                        i_seg_index,
    input  logic [1:0]                        i_seg_kind,
    input  logic [kcs_pkg::TIME_W-1:0]        i_start_time,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_start_value,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_ctrl1_value,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_ctrl2_value,
    input  logic [kcs_pkg::TIME_W-1:0]        i_end_time,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_end_value,
    input  logic [kcs_pkg::TIME_W-1:0]        i_query_time,
    output logic                              o_done,
    output logic signed [kcs_pkg::VAL_W-1:0]  o_curve_value,
    output logic                              o_found
);
    import kcs_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_seg_count;
    logic [CNT_W-1:0]        scan_n;
    logic [SEG_AW:0]         r_idx;
    logic                    r_rd_vld;
    logic [TIME_W-1:0]       r_query_time;
    logic signed [VAL_W-1:0] r_v0, r_v1, r_v2, r_v3;
    logic [1:0]              r_k, r_kmax;
    logic [TIME_W-1:0]       r_ratio;
    logic signed [2*VAL_W+1:0] r_prod;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_found;

    logic                    accept;
    logic                    wr_en;
    t_entry                  wr_data;
    logic                    rd_en;
    t_entry                  ent;
    logic                    match;
    logic                    more;
    logic [TIME_W-1:0]       offs;
    logic [TIME_W-1:0]       span;
    t_div                    chain [DIV_STEPS+1];
    logic signed [VAL_W-1:0] op_a, op_b;
    logic signed [VAL_W:0]   op_diff;
    logic signed [2*VAL_W+1:0] biased;
    logic signed [VAL_W-1:0] lerp_res;
    logic                    div_out;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && (r_state == ST_IDLE);

    // Segment count register; counts beyond the table scan the whole table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seg_count <= i_cfg_data;
        end
    end
    assign scan_n = (r_seg_count > CNT_MAX) ? CNT_MAX : r_seg_count;

    // Table write and scan read.
    assign wr_en = accept && (i_cmd == CMD_WRITE);
    always_comb begin
        wr_data.kind        = i_seg_kind;
        wr_data.start_time  = i_start_time;
        wr_data.start_value = i_start_value;
        wr_data.ctrl1_value = i_ctrl1_value;
        wr_data.ctrl2_value = i_ctrl2_value;
        wr_data.end_time    = i_end_time;
        wr_data.end_value   = i_end_value;
    end

    assign more  = ({1'b0, r_idx} < (SEG_AW+2)'(scan_n));
    assign match = r_rd_vld && (ent.start_time <= r_query_time)
                   && (r_query_time <= ent.end_time);
    assign rd_en = (r_state == ST_SCAN) && more && !match;

    kcs_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_seg_index[SEG_AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[SEG_AW-1:0]),
        .o_rd_data (ent)
    );

    // Divider chain: the ratio is floor((t - start) * 2^31 / span).
    assign offs = r_query_time - ent.start_time;
    assign span = ent.end_time - ent.start_time;
    always_comb begin
        chain[0].vld  = (r_state == ST_SCAN) && match;
        chain[0].rem  = {1'b0, offs[TIME_W-1:1]};
        chain[0].quo  = '0;
        chain[0].span = span;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        kcs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_div   (chain[g]),
            .i_bit   ((g == 0) ? offs[0] : 1'b0),
            .o_div   (chain[g+1])
        );
    end
    assign div_out = chain[DIV_STEPS].vld;

    // Lerp operands for the current pair.
    always_comb begin
        unique case (r_k)
            2'd0: begin
                op_a = r_v0;
                op_b = r_v1;
            end
            2'd1: begin
                op_a = r_v1;
                op_b = r_v2;
            end
            default: begin
                op_a = r_v2;
                op_b = r_v3;
            end
        endcase
        op_diff  = (VAL_W+1)'(op_b) - (VAL_W+1)'(op_a);
        biased   = r_prod + (2*VAL_W+2)'(64'sd1 <<< 30);
        lerp_res = op_a + VAL_W'(biased >>> 31);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_cmd == CMD_WRITE) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    n_state = ST_DIV;
                end else if (!r_rd_vld && !more) begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_out) begin
                    priority if (ent.kind == KIND_STEP || ent.kind == KIND_INVSTEP) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL:  n_state = ST_ADD;
            ST_ADD: begin
                if (r_k == r_kmax && r_kmax == 2'd0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (accept) begin
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rd_vld <= rd_en;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query_time <= i_query_time;
            r_value      <= '0;
            r_found      <= 1'b0;
        end
        if (chain[0].vld) begin
            r_found <= 1'b1;
            r_k     <= 2'd0;
            if (ent.kind == KIND_BEZIER) begin
                r_v0   <= ent.start_value;
                r_v1   <= ent.ctrl1_value;
                r_v2   <= ent.ctrl2_value;
                r_v3   <= ent.end_value;
                r_kmax <= 2'd2;
            end else begin
                r_v0   <= ent.start_value;
                r_v1   <= ent.end_value;
                r_kmax <= 2'd0;
            end
        end
        if (r_state == ST_DIV && div_out) begin
            r_ratio <= (chain[DIV_STEPS].span == '0) ? '0 : chain[DIV_STEPS].quo;
            if (ent.kind == KIND_STEP) begin
                r_value <= ent.start_value;
            end else if (ent.kind == KIND_INVSTEP) begin
                r_value <= ent.end_value;
            end
        end
        if (r_state == ST_MUL) begin
            r_prod <= op_diff * $signed({1'b0, r_ratio});
        end
        if (r_state == ST_ADD) begin
            unique case (r_k)
                2'd0:    r_v0 <= lerp_res;
                2'd1:    r_v1 <= lerp_res;
                default: r_v2 <= lerp_res;
            endcase
            if (r_k == r_kmax) begin
                r_k <= 2'd0;
                if (r_kmax == 2'd0) begin
                    r_value <= lerp_res;
                end else begin
                    r_kmax <= r_kmax - 2'd1;
                end
            end else begin
                r_k <= r_k + 2'd1;
            end
        end
    end

    // Outputs.
    always_comb begin
        o_busy        = (r_state != ST_IDLE);
        o_done        = (r_state == ST_DONE);
        o_curve_value = r_value;
        o_found       = (r_state == ST_DONE) && r_found;
    end

    // Checks.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe lasted more than one cycle");
    a_found_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> o_done) else $error("found raised outside a result");
    a_chain_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({chain[DIV_STEPS].vld, chain[DIV_STEPS/2].vld, chain[1].vld}))
        else $error("more than one division in the cell chain");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_out |-> (r_state == ST_DIV)) else $error("division ended outside its state");

endmodule

/* verif/kcs_checker.sv */
// Checker for the keyframe curve segment evaluator: keeps its own segment table and count,
// predicts each result, and compares it with what the block returns.
// Depends on kcs_pkg.
module kcs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [kcs_pkg::CNT_W-1:0]         i_cfg_data,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_cmd,
    input  logic [5:0]                        i_seg_index,
    input  logic [1:0]                        i_seg_kind,
    input  logic [kcs_pkg::TIME_W-1:0]        i_start_time,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_start_value,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_ctrl1_value,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_ctrl2_value,
    input  logic [kcs_pkg::TIME_W-1:0]        i_end_time,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_end_value,
    input  logic [kcs_pkg::TIME_W-1:0]        i_query_time,
    input  logic                              i_done,
    input  logic signed [kcs_pkg::VAL_W-1:0]  i_curve_value,
    input  logic                              i_found,
    output int                                o_fail_count,
    output int                                o_pending
);
    import kcs_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    found;
    } t_curve_result;

    t_entry        seg_table [MAX_SEGMENTS];
    int unsigned   seg_count;
    t_curve_result curve_q [$];

    // Blend a toward b by ratio r (Q1.31), rounding to nearest with ties upward.
    function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                                 logic [31:0] r);
        longint diff;
        longint prod;
        longint q;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(r);
        q    = (prod + (longint'(1) << 30)) >>> 31;
        return 32'(longint'(a) + q);
    endfunction

    // Scan the table for the first entry covering t and evaluate it.
    function automatic t_curve_result evaluate(logic [31:0] t);
        t_curve_result res;
        int unsigned   limit;
        logic [31:0]   span;
        logic [31:0]   r;
        logic [63:0]   num;
        logic signed [31:0] p01, p12, p23, p02, p13;
        t_entry        e;
        res.value = '0;
        res.found = 1'b0;
        limit = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : seg_count;
        for (int i = 0; i < limit; i++) begin
            e = seg_table[i];
            if (e.start_time <= t && t <= e.end_time) begin
                span = e.end_time - e.start_time;
                r = '0;
                if (span != 0) begin
                    num = 64'(t - e.start_time) << 31;
                    r = 32'(num / 64'(span));
                end
                res.found = 1'b1;
                case (t_kind'(e.kind))
                    KIND_LINEAR: res.value = blend(e.start_value, e.end_value, r);
                    KIND_BEZIER: begin
                        p01 = blend(e.start_value, e.ctrl1_value, r);
                        p12 = blend(e.ctrl1_value, e.ctrl2_value, r);
                        p23 = blend(e.ctrl2_value, e.end_value, r);
                        p02 = blend(p01, p12, r);
                        p13 = blend(p12, p23, r);
                        res.value = blend(p02, p13, r);
                    end
                    KIND_STEP:   res.value = e.start_value;
                    default:     res.value = e.end_value;
                endcase
                break;
            end
        end
        return res;
    endfunction

    task automatic report(string what, longint expv, longint gotv);
        $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, expv, gotv);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        seg_count    = 0;
    end

    always @(posedge i_clk) begin
        t_curve_result exp_res;
        if (!i_rst_n) begin
            seg_count = 0;
            curve_q.delete();
        end else begin
            // Compare a returned result with the oldest prediction.
            if (i_done) begin
                if (curve_q.size() == 0) begin
                    report("result with nothing expected", 0, i_curve_value);
                end else begin
                    exp_res = curve_q.pop_front();
                    if (i_found !== exp_res.found)
                        report("found", exp_res.found, i_found);
                    if (i_curve_value !== exp_res.value)
                        report("curve_value", exp_res.value, i_curve_value);
                end
            end
            // Count register transfer.
            if (i_cfg_valid && i_cfg_ready)
                seg_count = i_cfg_data;
            // Item transfer: writes load the table, queries scan it.
            if (i_start && !i_busy) begin
                exp_res.value = '0;
                exp_res.found = 1'b0;
                if (i_cmd == CMD_WRITE) begin
                    seg_table[i_seg_index] = '{i_seg_kind, i_start_time, i_start_value,
                                               i_ctrl1_value, i_ctrl2_value, i_end_time,
                                               i_end_value};
                end else begin
                    exp_res = evaluate(i_query_time);
                end
                curve_q.insert(curve_q.size(), exp_res);
            end
        end
        o_pending = curve_q.size();
    end

endmodule

/* verif/tb.sv */
// Testbench top for the keyframe curve segment evaluator: loads segment tables, sends queries
// with random idle gaps and gives the verdict.
// Depends on kcs_pkg, keyframe_curve_segment_evaluator and kcs_checker.
module tb;
    import kcs_pkg::*;

    localparam int SETTLE_CYCLES = 130;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         cfg_data;
    logic                     start;
    logic                     busy;
    logic                     cmd;
    logic [5:0]               seg_index;
    logic [1:0]               seg_kind;
    logic [TIME_W-1:0]        start_time;
    logic signed [VAL_W-1:0]  start_value;
    logic signed [VAL_W-1:0]  ctrl1_value;
    logic signed [VAL_W-1:0]  ctrl2_value;
    logic [TIME_W-1:0]        end_time;
    logic signed [VAL_W-1:0]  end_value;
    logic [TIME_W-1:0]        query_time;
    logic                     done;
    logic signed [VAL_W-1:0]  curve_value;
    logic                     found;
    int                       fail_count;
    int                       pending;

    // Span of each loaded entry, used to aim queries into segments.
    logic [31:0] span_start [MAX_SEGMENTS];
    logic [31:0] span_end   [MAX_SEGMENTS];
    int          idle_pct;

    keyframe_curve_segment_evaluator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_start(start), .o_busy(busy), .i_cmd(cmd), .i_seg_index(seg_index),
        .i_seg_kind(seg_kind), .i_start_time(start_time), .i_start_value(start_value),
        .i_ctrl1_value(ctrl1_value), .i_ctrl2_value(ctrl2_value), .i_end_time(end_time),
        .i_end_value(end_value), .i_query_time(query_time),
        .o_done(done), .o_curve_value(curve_value), .o_found(found)
    );

    kcs_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_start(start), .i_busy(busy), .i_cmd(cmd), .i_seg_index(seg_index),
        .i_seg_kind(seg_kind), .i_start_time(start_time), .i_start_value(start_value),
        .i_ctrl1_value(ctrl1_value), .i_ctrl2_value(ctrl2_value), .i_end_time(end_time),
        .i_end_value(end_value), .i_query_time(query_time),
        .i_done(done), .i_curve_value(curve_value), .i_found(found),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Pick a value, now and then one of the extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Transfer one item, at times after a random idle gap.
    task automatic send_item(logic c, logic [5:0] idx, logic [1:0] k, logic [31:0] st,
                             logic [31:0] et, logic [31:0] qt);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        seg_index   <= idx;
        seg_kind    <= k;
        start_time  <= st;
        start_value <= pick_value();
        ctrl1_value <= pick_value();
        ctrl2_value <= pick_value();
        end_time    <= et;
        end_value   <= pick_value();
        query_time  <= qt;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Load one entry. Shape: 0 short span, 1 zero span, 2 reversed, 3 whole range, 4 random.
    task automatic load_entry(int idx, int shape, logic [1:0] k);
        logic [31:0] st;
        logic [31:0] et;
        logic [32:0] sum;
        st = $urandom;
        case (shape)
            0: begin
                sum = 33'(st) + 33'($urandom_range(0, 1 << 20));
                et = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            1: et = st;
            2: begin
                if (st == 0) st = 1;
                et = st - 32'($urandom_range(1, 1000));
                if (et > st) et = 0;
            end
            3: begin
                st = 32'h0;
                et = 32'hFFFF_FFFF;
            end
            default: et = $urandom;
        endcase
        span_start[idx] = st;
        span_end[idx]   = et;
        send_item(CMD_WRITE, 6'(idx), k, st, et, $urandom);
    endtask

    // Query time: mostly inside or on the edge of some entry's span.
    function automatic logic [31:0] pick_time();
        int          idx;
        logic [63:0] width;
        idx = $urandom_range(MAX_SEGMENTS - 1);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                if (span_start[idx] > span_end[idx]) return span_start[idx];
                width = 64'(span_end[idx]) - 64'(span_start[idx]) + 1;
                return span_start[idx] + 32'({$urandom, $urandom} % width);
            end
            6:       return span_start[idx];
            7:       return span_end[idx];
            default: return $urandom;
        endcase
    endfunction

    task automatic send_query(logic [31:0] qt);
        send_item(CMD_QUERY, 6'($urandom), 2'($urandom), $urandom, $urandom, qt);
    endtask

    // Wait until the block is idle with nothing outstanding.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        start       = 1'b0;
        cmd         = CMD_WRITE;
        seg_index   = '0;
        seg_kind    = KIND_LINEAR;
        start_time  = '0;
        start_value = '0;
        ctrl1_value = '0;
        ctrl2_value = '0;
        end_time    = '0;
        end_value   = '0;
        query_time  = '0;
        idle_pct    = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty scan: nothing is ever found.
        write_count(7'd0);
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);

        // Fill the whole table; the first entries cover the special shapes and every kind.
        load_entry(0, 1, KIND_STEP);
        load_entry(1, 2, KIND_LINEAR);
        load_entry(2, 0, KIND_LINEAR);
        load_entry(3, 0, KIND_BEZIER);
        load_entry(4, 0, KIND_STEP);
        load_entry(5, 0, KIND_INVSTEP);
        load_entry(6, 3, KIND_BEZIER);
        for (int i = 7; i < MAX_SEGMENTS; i++)
            load_entry(i, $urandom_range(4), 2'($urandom));

        // Full scan, then a count above the table size.
        settle();
        write_count(7'd64);
        send_query(span_start[0]);
        send_query(span_start[1]);
        for (int i = 2; i < 6; i++) begin
            send_query(span_start[i]);
            send_query(span_end[i]);
        end
        send_query(32'h0);
        send_query(32'hFFFF_FFFF);
        settle();
        write_count(7'd127);
        send_query(pick_time());
        send_query(32'h7FFF_FFFF);

        // Random phases: sender idling now and then, mostly, then never.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 38 : (ph == 1) ? 87 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                settle();
                case (blk)
                    0:       write_count(7'd1);
                    1:       write_count(7'($urandom_range(2, 63)));
                    2:       write_count(7'd64);
                    default: write_count(7'($urandom_range(0, 127)));
                endcase
                for (int n = 0; n < 100; n++) begin
                    if ($urandom_range(3) == 0)
                        load_entry($urandom_range(MAX_SEGMENTS - 1), $urandom_range(4),
                                   2'($urandom));
                    else
                        send_query(pick_time());
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit.
    initial begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
rtl/kcs_pkg.sv
rtl/kcs_div_cell.sv
rtl/kcs_table.sv
rtl/keyframe_curve_segment_evaluator.sv
verif/kcs_checker.sv
verif/tb.sv
